@@ rtl/rnn_tanh_cell_encoder_defines.svh @@
// Assertion macros used by the top of the encoder RTL.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef RNN_TANH_CELL_ENCODER_DEFINES_SVH
`define RNN_TANH_CELL_ENCODER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RTCE_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RTCE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/rtce_pkg.sv @@
// Package for the recurrent tanh encoder: widths, register indexes, the
// sequencer states, the control struct and the tanh segment table. No dependencies.
package rtce_pkg;

  localparam int UNITS_MAX = 4;
  localparam int Q_W       = 16;   // Q3.12 sample and weight width
  localparam int H_W       = 14;   // hidden value width, -4096..4096
  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 3;
  localparam int ACC_W     = 34;   // exact sum of bias and up to five products
  localparam int LUT_W     = 12;   // table entries stay below 4096
  localparam int FRAC_W    = 10;
  localparam int SEG_W     = 4;
  localparam int DIFF_W    = 10;   // largest neighbor difference is 1003
  localparam int PROD_W    = DIFF_W + FRAC_W;

  localparam logic [CFG_IDX_W-1:0] CFG_INPUT_WEIGHTS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BIAS_VALUES   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REC_ROW_0     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REC_ROW_1     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_REC_ROW_2     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_REC_ROW_3     = 3'd5;

  localparam logic [H_W-2:0] ONE_Q12 = 13'd4096;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_TH1,
    ST_TH2,
    ST_FIN
  } rtce_state_t;

  // Control from the sequencer to every cell of the ring.
  typedef struct packed {
    logic       load;    // beat accepted: seed accumulator, load ring
    logic       clear;   // start of sequence: ring starts from zero
    logic       mac;     // one recurrent product, ring shifts
    logic [1:0] step;    // ring position during the MAC phase
    logic       th1;     // magnitude and rounding
    logic       th2;     // segment interpolation product
    logic       commit;  // new hidden value takes effect
    logic       emit;    // commit of a last beat, result is loaded
  } rtce_ctl_t;

  // round(4096 * tanh(k / 4)) for k = 0..16.
  function automatic logic [LUT_W-1:0] tanh_lut(input logic [SEG_W:0] k);
    logic [LUT_W-1:0] v;
    case (k)
      5'd0:    v = 12'd0;
      5'd1:    v = 12'd1003;
      5'd2:    v = 12'd1893;
      5'd3:    v = 12'd2602;
      5'd4:    v = 12'd3119;
      5'd5:    v = 12'd3475;
      5'd6:    v = 12'd3707;
      5'd7:    v = 12'd3856;
      5'd8:    v = 12'd3949;
      5'd9:    v = 12'd4006;
      5'd10:   v = 12'd4041;
      5'd11:   v = 12'd4062;
      5'd12:   v = 12'd4076;
      5'd13:   v = 12'd4084;
      5'd14:   v = 12'd4089;
      5'd15:   v = 12'd4091;
      5'd16:   v = 12'd4093;
      default: v = 12'd4093;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/rtce_in_if.sv @@
// Input channel: one sample beat with its sequence flags.
// Depends on rtce_pkg for the sample width.
interface rtce_in_if import rtce_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic signed [Q_W-1:0] sample;
  logic                 first_of_sequence;
  logic                 last_of_sequence;

  modport source (output valid, output sample, output first_of_sequence,
                  output last_of_sequence, input ready);
  modport sink   (input valid, input sample, input first_of_sequence,
                  input last_of_sequence, output ready);
endinterface

@@ rtl/rtce_out_if.sv @@
// Result channel: the final hidden vector of a sequence.
// Depends on rtce_pkg for the hidden width.
interface rtce_out_if import rtce_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic signed [H_W-1:0] hidden_0;
  logic signed [H_W-1:0] hidden_1;
  logic signed [H_W-1:0] hidden_2;
  logic signed [H_W-1:0] hidden_3;

  modport source (output valid, output hidden_0, output hidden_1, output hidden_2,
                  output hidden_3, input ready);
  modport sink   (input valid, input hidden_0, input hidden_1, input hidden_2,
                  input hidden_3, output ready);
endinterface

@@ rtl/rtce_seq.sv @@
// Sequencer of the encoder: walks one beat through seed, MAC ring, tanh and commit.
// Depends on rtce_pkg for the state enum and the control struct.
module rtce_seq import rtce_pkg::*; #(
  parameter int UNITS = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_first,
  input  logic      in_last,
  input  logic      out_busy,
  output logic      in_ready,
  output rtce_ctl_t ctl
);

  rtce_state_t state_r, state_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        last_r, last_nxt;

  // State, ring position and the held last flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      last_r  <= last_nxt;
    end
  end

  // Next state and cell controls.
  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    last_nxt   = last_r;
    in_ready   = 1'b0;
    ctl        = '0;
    ctl.step   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        in_ready  = 1'b1;
        ctl.load  = in_valid;
        ctl.clear = in_first;
        if (in_valid) begin
          last_nxt  = in_last;
          cnt_nxt   = '0;
          state_nxt = ST_MAC;
        end
      end
      ST_MAC: begin
        ctl.mac = 1'b1;
        if (cnt_r == 2'(UNITS - 1)) begin
          state_nxt = ST_TH1;
        end else begin
          cnt_nxt = cnt_r + 2'd1;
        end
      end
      ST_TH1: begin
        ctl.th1   = 1'b1;
        state_nxt = ST_TH2;
      end
      ST_TH2: begin
        ctl.th2   = 1'b1;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        // A last beat waits here until the result register is free.
        if (!last_r || !out_busy) begin
          ctl.commit = 1'b1;
          ctl.emit   = last_r;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/rtce_cell.sv @@
// One hidden unit of the ring: accumulator, one multiplier, tanh stages and its state.
// Depends on rtce_pkg for widths, the control struct and the tanh table.
module rtce_cell import rtce_pkg::*; #(
  parameter int UNITS = 4,
  parameter int IDX   = 0
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  rtce_ctl_t             ctl_i,
  input  logic signed [Q_W-1:0] sample_i,
  input  logic [Q_W-1:0]        weight_i,
  input  logic [Q_W-1:0]        bias_i,
  input  logic [CFG_W-1:0]      row_i,
  input  logic signed [H_W-1:0] ring_i,
  output logic signed [H_W-1:0] ring_o,
  output logic signed [H_W-1:0] hid_nxt_o
);

  logic signed [H_W-1:0]   h_r;
  logic signed [H_W-1:0]   ring_r;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic                    neg_r, sat_r, neg2_r, sat2_r;
  logic [SEG_W-1:0]        seg_r;
  logic [FRAC_W-1:0]       frac_r;
  logic [PROD_W-1:0]       prod_r;
  logic [LUT_W-1:0]        base_r;

  logic [2:0]              jsum;
  logic [1:0]              jidx;
  logic signed [Q_W-1:0]   rec_w, mul_a, mul_b;
  logic signed [2*Q_W-1:0] mul_p;
  logic signed [ACC_W-1:0] bias_ext, acc_base;
  logic [ACC_W-1:0]        mag, rnd;
  logic [ACC_W-13:0]       mq;
  logic [LUT_W-1:0]        t_lo, t_hi;
  logic [DIFF_W-1:0]       diff;
  logic [PROD_W:0]         prod_rnd;
  logic [H_W-2:0]          ymag;

  // Column of the hidden value that sits in this cell at the current ring step.
  assign jsum  = 3'(IDX) + {1'b0, ctl_i.step};
  assign jidx  = (jsum >= 3'(UNITS)) ? 2'(jsum - 3'(UNITS)) : jsum[1:0];
  assign rec_w = row_i[{jidx, 4'b0000} +: Q_W];

  // Shared multiplier: input weight times sample on load, else a recurrent term.
  assign mul_a    = ctl_i.load ? signed'(weight_i) : rec_w;
  assign mul_b    = ctl_i.load ? sample_i : Q_W'(ring_r);
  assign mul_p    = mul_a * mul_b;
  assign bias_ext = {{(ACC_W - Q_W - 12){bias_i[Q_W-1]}}, bias_i, 12'b0};
  assign acc_base = ctl_i.load ? bias_ext : acc_r;
  assign acc_nxt  = acc_base + {{(ACC_W - 2*Q_W){mul_p[2*Q_W-1]}}, mul_p};

  // Magnitude rounded half away from zero to Q.12.
  assign mag = acc_r[ACC_W-1] ? ACC_W'(-acc_r) : ACC_W'(acc_r);
  assign rnd = mag + ACC_W'(2048);
  assign mq  = rnd[ACC_W-1:12];

  // Table neighbors of the segment.
  assign t_lo = tanh_lut({1'b0, seg_r});
  assign t_hi = tanh_lut({1'b0, seg_r} + 5'd1);
  assign diff = DIFF_W'(t_hi - t_lo);

  // Interpolated, saturated and signed result.
  assign prod_rnd  = {1'b0, prod_r} + (PROD_W + 1)'(512);
  assign ymag      = sat2_r ? ONE_Q12 : (H_W - 1)'(base_r) + (H_W - 1)'(prod_rnd[PROD_W:10]);
  assign hid_nxt_o = neg2_r ? -signed'({1'b0, ymag}) : signed'({1'b0, ymag});
  assign ring_o    = ring_r;

  // Hidden state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_r <= '0;
    end else if (ctl_i.commit) begin
      h_r <= hid_nxt_o;
    end
  end

  // Accumulator and ring register.
  always_ff @(posedge clk) begin
    if (ctl_i.load) begin
      acc_r  <= acc_nxt;
      ring_r <= ctl_i.clear ? '0 : h_r;
    end else if (ctl_i.mac) begin
      acc_r  <= acc_nxt;
      ring_r <= ring_i;
    end
  end

  // Tanh pipeline: rounding and segment split, then the interpolation product.
  always_ff @(posedge clk) begin
    if (ctl_i.th1) begin
      neg_r  <= acc_r[ACC_W-1];
      sat_r  <= |mq[ACC_W-13:14];
      seg_r  <= mq[13:10];
      frac_r <= mq[9:0];
    end
    if (ctl_i.th2) begin
      neg2_r <= neg_r;
      sat2_r <= sat_r;
      base_r <= t_lo;
      prod_r <= diff * frac_r;
    end
  end

endmodule

@@ rtl/rnn_tanh_cell_encoder.sv @@
// Elman tanh encoder cell: a ring of hidden-unit cells fed by one sequencer.
// Throughput: a new beat is accepted only after the previous one commits, a pace set
// by the shared multiplier of each cell, which takes one recurrent term per cycle as
// the ring shifts; a last beat also waits while the previous result is still held.
// Reset (synchronous, rst_n low) clears the hidden vector, the configuration registers
// and the result valid; the datapath registers are reloaded by every beat.
module rnn_tanh_cell_encoder import rtce_pkg::*; #(
  parameter int HIDDEN_UNITS = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  rtce_in_if.sink              in_ch,
  rtce_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  `include "rnn_tanh_cell_encoder_defines.svh"

  logic [CFG_W-1:0]      in_w_r;
  logic [CFG_W-1:0]      bias_r;
  logic [CFG_W-1:0]      row_r [UNITS_MAX];
  logic                  out_valid_r, out_valid_nxt;
  logic signed [H_W-1:0] hid_r [UNITS_MAX];
  logic signed [H_W-1:0] hid_nxt [UNITS_MAX];
  logic signed [H_W-1:0] ring [UNITS_MAX];
  logic                  out_busy;
  rtce_ctl_t             ctl;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_w_r <= '0;
      bias_r <= '0;
      for (int i = 0; i < UNITS_MAX; i++) begin
        row_r[i] <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_INPUT_WEIGHTS: in_w_r   <= cfg_wdata;
        CFG_BIAS_VALUES:   bias_r   <= cfg_wdata;
        CFG_REC_ROW_0:     row_r[0] <= cfg_wdata;
        CFG_REC_ROW_1:     row_r[1] <= cfg_wdata;
        CFG_REC_ROW_2:     row_r[2] <= cfg_wdata;
        CFG_REC_ROW_3:     row_r[3] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign out_busy = out_valid_r && !out_ch.ready;

  rtce_seq #(.UNITS(HIDDEN_UNITS)) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_first (in_ch.first_of_sequence),
    .in_last  (in_ch.last_of_sequence),
    .out_busy (out_busy),
    .in_ready (in_ch.ready),
    .ctl      (ctl)
  );

  // Ring of cells; each takes its neighbor's hidden value every MAC cycle.
  for (genvar u = 0; u < UNITS_MAX; u++) begin : g_unit
    if (u < HIDDEN_UNITS) begin : g_cell
      rtce_cell #(.UNITS(HIDDEN_UNITS), .IDX(u)) u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl_i     (ctl),
        .sample_i  (in_ch.sample),
        .weight_i  (in_w_r[u*Q_W +: Q_W]),
        .bias_i    (bias_r[u*Q_W +: Q_W]),
        .row_i     (row_r[u]),
        .ring_i    (ring[(u + 1) % HIDDEN_UNITS]),
        .ring_o    (ring[u]),
        .hid_nxt_o (hid_nxt[u])
      );
    end else begin : g_off
      assign ring[u]    = '0;
      assign hid_nxt[u] = '0;
    end
  end

  // Result register: loaded on the commit of a last beat, held until taken.
  assign out_valid_nxt = ctl.emit ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      for (int i = 0; i < UNITS_MAX; i++) begin
        hid_r[i] <= hid_nxt[i];
      end
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.hidden_0 = hid_r[0];
  assign out_ch.hidden_1 = hid_r[1];
  assign out_ch.hidden_2 = hid_r[2];
  assign out_ch.hidden_3 = hid_r[3];

  // Checks on the sequencing.
  `RTCE_ASSERT_IMPL(a_emit_free, ctl.emit, !out_valid_r || out_ch.ready, "result overwritten while waiting")
  `RTCE_ASSERT_IMPL(a_rose_emit, $rose(out_valid_r), $past(ctl.emit), "result valid without a commit")
  `RTCE_ASSERT_NEXT(a_load_mac, in_ch.valid && in_ch.ready, ctl.mac, "accepted beat did not enter the ring")

endmodule

@@ verif/rtce_hidden_checker.sv @@
// Checker for the recurrent tanh encoder: predicts the final hidden vector of every
// sequence from the watched beats and register writes and compares the results.
// Depends on rtce_pkg and on the rtce_in_if and rtce_out_if channel interfaces.
module rtce_hidden_checker import rtce_pkg::*; #(
  parameter int HIDDEN_UNITS = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  rtce_in_if                   in_ch,
  rtce_out_if                  out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output int                   mismatches,
  output int                   pending,
  output int                   vectors_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Q12_ONE   = 4096;
  localparam int SAT_LEVEL = 16384;  // rounded magnitude of 4.0 and above saturates
  localparam int SEG_SHIFT = 10;
  localparam int REPORT_MAX = 10;

  typedef logic [UNITS_MAX-1:0][H_W-1:0] hvec_t;

  // Breakpoints of the tanh curve at steps of 0.25, in Q.12.
  int tanh_knots [0:16] = '{0, 1003, 1893, 2602, 3119, 3475, 3707, 3856, 3949,
                            4006, 4041, 4062, 4076, 4084, 4089, 4091, 4093};

  logic [CFG_W-1:0] in_weights;
  logic [CFG_W-1:0] unit_bias;
  logic [CFG_W-1:0] rec_rows [UNITS_MAX];
  int               hidden_now [UNITS_MAX];
  hvec_t            expected_vectors [$];

  // Signed Q3.12 value from one 16-bit lane of a packed register.
  function automatic int lane_q12(input logic [CFG_W-1:0] word, input int idx);
    return int'($signed(word[idx*Q_W +: Q_W]));
  endfunction

  // Round the Q7.24 sum to Q.12, then interpolate on the curve, odd-symmetric.
  function automatic int tanh_q12(input longint acc);
    longint mag;
    longint rounded;
    int     seg;
    int     frac;
    int     rise;
    int     y;
    mag     = (acc < 0) ? -acc : acc;
    rounded = (mag + 2048) >>> 12;
    if (rounded >= SAT_LEVEL) begin
      y = Q12_ONE;
    end else begin
      seg  = int'(rounded >>> SEG_SHIFT);
      frac = int'(rounded & 1023);
      rise = tanh_knots[seg+1] - tanh_knots[seg];
      y    = tanh_knots[seg] + ((rise * frac + 512) >>> SEG_SHIFT);
    end
    return (acc < 0) ? -y : y;
  endfunction

  // One time step of the cell; queues the hidden vector when the sequence ends.
  task automatic advance_cell(input int x, input logic first, input logic last);
    longint acc;
    int     next_h [UNITS_MAX];
    hvec_t  vec;
    if (first) begin
      for (int i = 0; i < UNITS_MAX; i++) hidden_now[i] = 0;
    end
    for (int i = 0; i < UNITS_MAX; i++) begin
      next_h[i] = 0;
      if (i < HIDDEN_UNITS) begin
        acc = longint'(lane_q12(unit_bias, i)) * Q12_ONE
            + longint'(lane_q12(in_weights, i)) * x;
        for (int j = 0; j < HIDDEN_UNITS; j++) begin
          acc += longint'(lane_q12(rec_rows[i], j)) * hidden_now[j];
        end
        next_h[i] = tanh_q12(acc);
      end
    end
    for (int i = 0; i < UNITS_MAX; i++) begin
      hidden_now[i] = next_h[i];
      vec[i]        = H_W'(next_h[i]);
    end
    if (last) expected_vectors.push_back(vec);
  endtask

  // Compare one result beat with the oldest expected vector.
  task automatic check_result(input hvec_t got);
    hvec_t want;
    if (expected_vectors.size() == 0) begin
      if (mismatches < REPORT_MAX) begin
        $display("[%0t] unexpected hidden vector %0d %0d %0d %0d", $realtime,
                 $signed(got[0]), $signed(got[1]), $signed(got[2]), $signed(got[3]));
      end
      mismatches++;
    end else begin
      want = expected_vectors.pop_front();
      vectors_checked++;
      if (got !== want) begin
        if (mismatches < REPORT_MAX) begin
          $display("[%0t] hidden vector mismatch: expected %0d %0d %0d %0d, got %0d %0d %0d %0d",
                   $realtime,
                   $signed(want[0]), $signed(want[1]), $signed(want[2]), $signed(want[3]),
                   $signed(got[0]), $signed(got[1]), $signed(got[2]), $signed(got[3]));
        end
        mismatches++;
      end
    end
  endtask

  // Results are taken before new beats, since a result never comes from
  // a beat accepted at the same edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_weights = '0;
      unit_bias  = '0;
      for (int i = 0; i < UNITS_MAX; i++) begin
        rec_rows[i]   = '0;
        hidden_now[i] = 0;
      end
      expected_vectors.delete();
      pending <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_INPUT_WEIGHTS: in_weights  = cfg_wdata;
          CFG_BIAS_VALUES:   unit_bias   = cfg_wdata;
          CFG_REC_ROW_0:     rec_rows[0] = cfg_wdata;
          CFG_REC_ROW_1:     rec_rows[1] = cfg_wdata;
          CFG_REC_ROW_2:     rec_rows[2] = cfg_wdata;
          CFG_REC_ROW_3:     rec_rows[3] = cfg_wdata;
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        check_result({out_ch.hidden_3, out_ch.hidden_2, out_ch.hidden_1, out_ch.hidden_0});
      end
      if (in_ch.valid && in_ch.ready) begin
        advance_cell(int'($signed(in_ch.sample)), in_ch.first_of_sequence,
                     in_ch.last_of_sequence);
      end
      pending <= expected_vectors.size();
    end
  end

endmodule

@@ verif/tb.sv @@
// Top of the encoder testbench: clock, reset, register settings, sample beats
// and receiver stalls, with the verdict. Depends on rtce_pkg, both channel
// interfaces, rnn_tanh_cell_encoder and rtce_hidden_checker.
module tb;
  import rtce_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HIDDEN_UNITS  = 4;
  localparam int LATENCY       = HIDDEN_UNITS + 4;
  localparam int SETTLE        = LATENCY + 4;
  localparam int IDLE_LIMIT    = 2000;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_BEATS   = 150;

  // Indexes that decode to no register.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

  // How the four lanes of a register are filled.
  typedef enum {MIX_ZERO, MIX_MAXPOS, MIX_MAXNEG, MIX_FULL, MIX_SMALL} mix_t;

  // Receiver stall patterns, chosen by the top two bits of the free-running stall clock.
  typedef enum logic [1:0] {RDY_OPEN, RDY_COIN, RDY_COMB, RDY_SPARSE} ready_mode_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  int          mismatches;
  int          pending;
  int          vectors_checked;
  int          beats_sent;
  int          settings_loaded;
  int          burst_left;
  int          idle_cycles;
  bit          steady;
  logic [11:0] stall_clock;

  rtce_in_if  in_ch();
  rtce_out_if out_ch();

  rnn_tanh_cell_encoder #(.HIDDEN_UNITS(HIDDEN_UNITS)) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  rtce_hidden_checker #(.HIDDEN_UNITS(HIDDEN_UNITS)) u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ch           (in_ch),
    .out_ch          (out_ch),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .mismatches      (mismatches),
    .pending         (pending),
    .vectors_checked (vectors_checked)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Receiver: ready follows the current stall pattern.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_clock  <= '0;
    end else begin
      stall_clock <= stall_clock + 1'b1;
      case (ready_mode_t'(stall_clock[11:10]))
        RDY_OPEN:   out_ch.ready <= 1'b1;
        RDY_COIN:   out_ch.ready <= 1'($urandom_range(0, 1));
        RDY_COMB:   out_ch.ready <= (stall_clock[3:0] == 4'd0);
        RDY_SPARSE: out_ch.ready <= ($urandom_range(0, 7) == 0);
        default:    out_ch.ready <= 1'b1;
      endcase
    end
  end

  // Watchdog: too long without any beat or register write ends the run.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic logic [CFG_W-1:0] pack_lanes(input mix_t kind);
    logic [CFG_W-1:0] word;
    for (int i = 0; i < UNITS_MAX; i++) begin
      case (kind)
        MIX_ZERO:   word[i*Q_W +: Q_W] = '0;
        MIX_MAXPOS: word[i*Q_W +: Q_W] = 16'h7FFF;
        MIX_MAXNEG: word[i*Q_W +: Q_W] = 16'h8000;
        MIX_FULL:   word[i*Q_W +: Q_W] = Q_W'($urandom);
        default:    word[i*Q_W +: Q_W] = Q_W'(int'($urandom_range(0, 4096)) - 2048);
      endcase
    end
    return word;
  endfunction

  // Small weights in half of the picks, so the curve is exercised between the rails.
  function automatic mix_t pick_mix();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return MIX_ZERO;
    if (r == 1) return MIX_MAXPOS;
    if (r == 2) return MIX_MAXNEG;
    if (r <= 4) return MIX_FULL;
    return MIX_SMALL;
  endfunction

  function automatic logic [Q_W-1:0] pick_sample();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'h7FFF;
    if (r == 1) return 16'h8000;
    if (r <= 4) return Q_W'($urandom);
    return Q_W'(int'($urandom_range(0, 8192)) - 4096);
  endfunction

  task automatic push_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  // Writes all six registers, then junk to the spare indexes.
  task automatic load_settings(input mix_t wk, input mix_t bk, input mix_t rk);
    push_reg(CFG_INPUT_WEIGHTS, pack_lanes(wk));
    push_reg(CFG_BIAS_VALUES, pack_lanes(bk));
    push_reg(CFG_REC_ROW_0, pack_lanes(rk));
    push_reg(CFG_REC_ROW_1, pack_lanes(rk));
    push_reg(CFG_REC_ROW_2, pack_lanes(rk));
    push_reg(CFG_REC_ROW_3, pack_lanes(rk));
    push_reg(CFG_SPARE_A, {$urandom, $urandom});
    push_reg(CFG_SPARE_B, {$urandom, $urandom});
    cfg_we <= 1'b0;
    @(posedge clk);
    settings_loaded++;
  endtask

  // Sends one beat; between bursts the sender idles for a random gap.
  task automatic next_beat(input logic [Q_W-1:0] s, input logic first, input logic last);
    int gap;
    if (burst_left == 0) begin
      gap = steady ? 0 : $urandom_range(0, 6);
      if (!steady && $urandom_range(0, 15) == 0) gap = $urandom_range(7, 24);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_ch.valid             <= 1'b1;
    in_ch.sample            <= s;
    in_ch.first_of_sequence <= first;
    in_ch.last_of_sequence  <= last;
    do @(posedge clk); while (!in_ch.ready);
    beats_sent++;
  endtask

  // Waits for every expected vector, then lets a trailing step finish.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin
    int seq_len;
    rst_n                   = 1'b0;
    cfg_we                  = 1'b0;
    cfg_index               = '0;
    cfg_wdata               = '0;
    in_ch.valid             = 1'b0;
    in_ch.sample            = '0;
    in_ch.first_of_sequence = 1'b0;
    in_ch.last_of_sequence  = 1'b0;
    beats_sent              = 0;
    settings_loaded         = 0;
    burst_left              = 0;
    steady                  = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Registers still at reset: every sum is zero.
    next_beat(16'h7FFF, 1'b1, 1'b1);
    next_beat(16'h8000, 1'b1, 1'b1);
    drain();

    // Largest positive weights: sums saturate high, and low for the most negative sample.
    load_settings(MIX_MAXPOS, MIX_MAXPOS, MIX_MAXPOS);
    next_beat(16'h7FFF, 1'b1, 1'b1);
    next_beat(16'h0000, 1'b1, 1'b1);
    next_beat(16'h8000, 1'b1, 1'b1);
    drain();

    // Largest negative weights, with a two-step sequence through the recurrence.
    load_settings(MIX_MAXNEG, MIX_MAXNEG, MIX_MAXNEG);
    next_beat(16'h8000, 1'b1, 1'b1);
    next_beat(16'h7FFF, 1'b1, 1'b1);
    next_beat(16'h0000, 1'b1, 1'b0);
    next_beat(16'h0000, 1'b0, 1'b1);
    drain();

    // Small weights: interpolation, sequences that continue without a first
    // flag, and first and last on one beat.
    load_settings(MIX_SMALL, MIX_SMALL, MIX_SMALL);
    next_beat(16'h8000, 1'b1, 1'b0);
    next_beat(16'h7FFF, 1'b0, 1'b0);
    next_beat(16'hFFFF, 1'b0, 1'b0);
    next_beat(16'h0001, 1'b0, 1'b1);
    next_beat(16'h0800, 1'b0, 1'b1);
    next_beat(16'hF800, 1'b0, 1'b0);
    next_beat(16'h1000, 1'b1, 1'b1);
    next_beat(16'h0000, 1'b0, 1'b1);
    drain();

    // Random part: mostly whole sequences, some beats with random flags.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      load_settings(pick_mix(), pick_mix(), pick_mix());
      steady = (phase % 4 == 3);
      for (int n = 0; n < PHASE_BEATS; n += seq_len) begin
        if ($urandom_range(0, 9) < 8) begin
          seq_len = $urandom_range(1, 10);
          for (int k = 0; k < seq_len; k++) begin
            next_beat(pick_sample(), k == 0, k == seq_len - 1);
          end
        end else begin
          seq_len = 1;
          next_beat(pick_sample(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
      end
      drain();
    end

    $display("tb: %0d sample beats under %0d register settings, %0d hidden vectors compared",
             beats_sent, settings_loaded + 1, vectors_checked);
    if (mismatches == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ rnn_tanh_cell_encoder.f @@
+incdir+rtl
rtl/rtce_pkg.sv
rtl/rtce_in_if.sv
rtl/rtce_out_if.sv
rtl/rtce_seq.sv
rtl/rtce_cell.sv
rtl/rnn_tanh_cell_encoder.sv
verif/rtce_hidden_checker.sv
verif/tb.sv
